// ===== hw/rtl/region_color_homogeneity_check_defines.svh =====
// Assertion macros shared by the region colour homogeneity check modules
`ifndef REGION_COLOR_HOMOGENEITY_CHECK_DEFINES_SVH
`define REGION_COLOR_HOMOGENEITY_CHECK_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RCHC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define RCHC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rchc_pkg.sv =====
// Types and constants of the region colour homogeneity check
package rchc_pkg;

  localparam int unsigned COMP_W  = 8;
  localparam int unsigned SQ_W    = 2 * COMP_W;
  localparam int unsigned SUM_W   = 18;
  localparam int unsigned MAG_W   = 9;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ADDR_W  = 3;

  localparam logic [MAG_W-1:0] LOWEST_RESET = 9'd511;
  localparam logic [MAG_W-1:0] TOL_RESET    = 9'd16;
  localparam logic [MAG_W-1:0] MAG_MAX      = 9'd441;

  localparam logic [0:0] REG_TOLERANCE = 1'b0;

  localparam logic [1:0] CHAN_RED   = 2'd0;
  localparam logic [1:0] CHAN_GREEN = 2'd1;
  localparam logic [1:0] CHAN_BLUE  = 2'd2;

  localparam logic [3:0]       ROOT_LAST_STEP = 4'd8;
  localparam logic [SUM_W-1:0] ROOT_FIRST_BIT = 18'h10000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQ,
    ST_ROOT,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] root;
  } sqrt_rsp_t;

endpackage

// ===== hw/rtl/region_color_homogeneity_check.sv =====
// Top level: pixel magnitude, min/max tracking and region homogeneity result
// A pixel is accepted in the idle state, squared channel by channel on the shared
// 8x8 squarer, reduced by the bit-serial square root and then applied in the tracker
// update; no new pixel is accepted until the previous one has finished the update.
// Reset (synchronous, rst_n low): idle, no result pending, trackers at
// 511 and 0, tolerance 16.
`include "region_color_homogeneity_check_defines.svh"

module region_color_homogeneity_check import rchc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [COMP_W-1:0] in_red,
  input  logic [COMP_W-1:0] in_green,
  input  logic [COMP_W-1:0] in_blue,
  input  logic              in_last_pixel,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_homogeneous,
  output logic [MAG_W-1:0]  out_spread,
  output logic [MAG_W-1:0]  out_min_magnitude,
  output logic [MAG_W-1:0]  out_max_magnitude,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  state_t           state_r, state_nxt;
  logic [1:0]       chan_r, chan_nxt;
  logic [COMP_W-1:0] red_r, green_r, blue_r;
  logic             last_r;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [MAG_W-1:0] mag_r;
  logic [MAG_W-1:0] lowest_r, lowest_nxt;
  logic [MAG_W-1:0] highest_r, highest_nxt;
  logic [MAG_W-1:0] tol_r, tol_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_homog_r;
  logic [MAG_W-1:0] out_spread_r, out_min_r, out_max_r;

  logic [COMP_W-1:0] comp;
  logic [SQ_W-1:0]   sq;
  logic [MAG_W-1:0]  lo_new, hi_new, spread_new;
  logic              out_free, out_load, trk_load, cfg_wr, cfg_hit;

  sqrt_req_t sqrt_req;
  sqrt_rsp_t sqrt_rsp;

  rchc_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sqrt_req),
    .rsp   (sqrt_rsp)
  );

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[2:2] == REG_TOLERANCE);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_hit;
  assign cfg_prdata = cfg_hit ? DATA_W'(tol_r) : '0;
  assign tol_nxt    = cfg_wr ? cfg_pwdata[MAG_W-1:0] : tol_r;

  // datapath
  always_comb begin
    case (chan_r)
      CHAN_RED:   comp = red_r;
      CHAN_GREEN: comp = green_r;
      default:    comp = blue_r;
    endcase
  end

  assign sq         = SQ_W'(comp) * SQ_W'(comp);
  assign sum_nxt    = sum_r + SUM_W'(sq);
  assign lo_new     = (mag_r < lowest_r)  ? mag_r : lowest_r;
  assign hi_new     = (mag_r > highest_r) ? mag_r : highest_r;
  assign spread_new = hi_new - lo_new;
  assign out_free   = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_SQ;
      ST_SQ:   if (chan_r == CHAN_BLUE) state_nxt = ST_ROOT;
      ST_ROOT: if (sqrt_rsp.done) state_nxt = ST_UPD;
      ST_UPD:  if (!last_r || out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready          = 1'b0;
    sqrt_req.start    = 1'b0;
    sqrt_req.radicand = sum_nxt;
    out_load          = 1'b0;
    trk_load          = 1'b0;
    chan_nxt          = chan_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        chan_nxt = CHAN_RED;
      end
      ST_SQ: begin
        chan_nxt       = chan_r + 2'd1;
        sqrt_req.start = (chan_r == CHAN_BLUE);
      end
      ST_UPD: begin
        trk_load = !last_r || out_free;
        out_load = last_r && out_free;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    lowest_nxt  = lowest_r;
    highest_nxt = highest_r;
    if (trk_load) begin
      if (last_r) begin
        lowest_nxt  = LOWEST_RESET;
        highest_nxt = '0;
      end else begin
        lowest_nxt  = lo_new;
        highest_nxt = hi_new;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (out_load)                 out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chan_r      <= CHAN_RED;
      lowest_r    <= LOWEST_RESET;
      highest_r   <= '0;
      tol_r       <= TOL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chan_r      <= chan_nxt;
      lowest_r    <= lowest_nxt;
      highest_r   <= highest_nxt;
      tol_r       <= tol_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      red_r   <= in_red;
      green_r <= in_green;
      blue_r  <= in_blue;
      last_r  <= in_last_pixel;
      sum_r   <= '0;
    end else if (state_r == ST_SQ) begin
      sum_r <= sum_nxt;
    end
    if (state_r == ST_ROOT && sqrt_rsp.done) begin
      mag_r <= sqrt_rsp.root;
    end
    if (out_load) begin
      out_homog_r  <= (spread_new < tol_r);
      out_spread_r <= spread_new;
      out_min_r    <= lo_new;
      out_max_r    <= hi_new;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_homogeneous   = out_homog_r;
  assign out_spread        = out_spread_r;
  assign out_min_magnitude = out_min_r;
  assign out_max_magnitude = out_max_r;

  `RCHC_ASSERT_SAME(a_out_order, out_valid_r, out_min_r <= out_max_r, "min above max")
  `RCHC_ASSERT_SAME(a_out_spread, out_valid_r, out_spread_r == out_max_r - out_min_r,
                    "spread mismatch")
  `RCHC_ASSERT_SAME(a_root_state, sqrt_rsp.done, state_r == ST_ROOT, "root done out of turn")
  `RCHC_ASSERT_NEXT(a_accept_sq, in_valid && in_ready, state_r == ST_SQ && chan_r == CHAN_RED,
                    "accepted request not squared")

endmodule

// ===== hw/rtl/rchc_isqrt.sv =====
// Bit-serial integer square root of an 18-bit sum, one root bit per cycle
`include "region_color_homogeneity_check_defines.svh"

module rchc_isqrt import rchc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  sqrt_req_t req,
  output sqrt_rsp_t rsp
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [SUM_W-1:0] v_r, v_nxt;
  logic [SUM_W-1:0] root_r, root_nxt;
  logic [SUM_W-1:0] bit_r, bit_nxt;
  logic [SUM_W-1:0] trial;

  assign trial = root_r + bit_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    v_nxt    = v_r;
    root_nxt = root_r;
    bit_nxt  = bit_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      v_nxt    = req.radicand;
      root_nxt = '0;
      bit_nxt  = ROOT_FIRST_BIT;
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_nxt    = v_r - trial;
        root_nxt = (root_r >> 1) + bit_r;
      end else begin
        root_nxt = root_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == ROOT_LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    root_r <= root_nxt;
    bit_r  <= bit_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r[MAG_W-1:0];

  `RCHC_ASSERT_SAME(a_start_idle, req.start, !busy_r && !done_r, "root started while busy")
  `RCHC_ASSERT_SAME(a_root_range, done_r, root_r <= SUM_W'(MAG_MAX), "root out of range")
  `RCHC_ASSERT_SAME(a_root_exact, done_r, (SUM_W+1)'(v_r) <= ((SUM_W+1)'(root_r) << 1),
                    "remainder exceeds twice the root")

endmodule

// ===== bench/tb_region_color_homogeneity_check.sv =====
// Testbench for the region colour homogeneity check: random regions, scoreboard, APB setup
`timescale 1ns / 1ps

import rchc_pkg::*;

class homogeneity_scoreboard;
  typedef struct packed {
    logic             homogeneous;
    logic [MAG_W-1:0] spread;
    logic [MAG_W-1:0] min_mag;
    logic [MAG_W-1:0] max_mag;
  } region_summary_t;

  logic [MAG_W-1:0] tolerance;
  logic [MAG_W-1:0] lowest;
  logic [MAG_W-1:0] highest;
  region_summary_t  expected_regions[$];
  int unsigned      mismatches;

  function new();
    tolerance  = TOL_RESET;
    lowest     = LOWEST_RESET;
    highest    = '0;
    mismatches = 0;
  endfunction

  function int unsigned pending();
    return expected_regions.size();
  endfunction

  function void report(string what, int unsigned got, int unsigned want);
    if (mismatches < 40) $display("mismatch: %s got %0d want %0d", what, got, want);
    mismatches++;
  endfunction

  // floor of the square root, built from the top bit down
  static function logic [MAG_W-1:0] magnitude(logic [COMP_W-1:0] r, g, b);
    int unsigned sum;
    int unsigned root;
    int unsigned trial;
    sum  = 32'(r) * 32'(r) + 32'(g) * 32'(g) + 32'(b) * 32'(b);
    root = 0;
    for (int i = MAG_W - 1; i >= 0; i--) begin
      trial = root | (1 << i);
      if (trial * trial <= sum) root = trial;
    end
    return MAG_W'(root);
  endfunction

  function void note_pixel(logic [COMP_W-1:0] r, g, b, logic last);
    logic [MAG_W-1:0] mag;
    region_summary_t  summary;
    mag = magnitude(r, g, b);
    if (mag < lowest) lowest = mag;
    if (mag > highest) highest = mag;
    if (last) begin
      summary.spread      = highest - lowest;
      summary.homogeneous = (summary.spread < tolerance);
      summary.min_mag     = lowest;
      summary.max_mag     = highest;
      expected_regions.push_back(summary);
      lowest  = LOWEST_RESET;
      highest = '0;
    end
  endfunction

  function void check_result(logic homogeneous, logic [MAG_W-1:0] spread, min_mag, max_mag);
    region_summary_t want;
    if (expected_regions.size() == 0) begin
      report("result with no region pending", 32'(spread), 0);
      return;
    end
    want = expected_regions.pop_front();
    if (homogeneous !== want.homogeneous)
      report("homogeneous", 32'(homogeneous), 32'(want.homogeneous));
    if (spread !== want.spread) report("spread", 32'(spread), 32'(want.spread));
    if (min_mag !== want.min_mag) report("min_magnitude", 32'(min_mag), 32'(want.min_mag));
    if (max_mag !== want.max_mag) report("max_magnitude", 32'(max_mag), 32'(want.max_mag));
  endfunction
endclass

module tb_region_color_homogeneity_check;
  localparam int unsigned     REG_COUNT     = 1;
  localparam logic [ADDR_W-1:0] TOL_ADDR    = ADDR_W'(4 * REG_TOLERANCE);
  localparam logic [ADDR_W-1:0] UNUSED_ADDR = ADDR_W'(4 * REG_COUNT);
  localparam int unsigned     SETTLE_CYCLES = 24;
  localparam int unsigned     LONG_HOLD     = 400;
  localparam int unsigned     CYCLE_LIMIT   = 300000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [COMP_W-1:0] in_red;
  logic [COMP_W-1:0] in_green;
  logic [COMP_W-1:0] in_blue;
  logic              in_last_pixel;
  logic              out_valid;
  logic              out_ready;
  logic              out_homogeneous;
  logic [MAG_W-1:0]  out_spread;
  logic [MAG_W-1:0]  out_min_magnitude;
  logic [MAG_W-1:0]  out_max_magnitude;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [DATA_W-1:0] cfg_pwdata;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  homogeneity_scoreboard sb = new();
  int unsigned src_gap_max = 6;
  int unsigned snk_gap_max = 6;
  bit          hold_pending = 1'b0;
  int unsigned cycle_count = 0;

  region_color_homogeneity_check dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .in_last_pixel     (in_last_pixel),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_homogeneous   (out_homogeneous),
    .out_spread        (out_spread),
    .out_min_magnitude (out_min_magnitude),
    .out_max_magnitude (out_max_magnitude),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_pixel(input logic [COMP_W-1:0] r, g, b, input logic last);
    int unsigned gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_red        <= r;
    in_green      <= g;
    in_blue       <= b;
    in_last_pixel <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(r, g, b, last);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic write, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data, output logic [DATA_W-1:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic program_register(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] rdata;
    apb_access(1'b1, addr, data, rdata);
    if (addr == TOL_ADDR) begin
      sb.tolerance = data[MAG_W-1:0];
      apb_access(1'b0, addr, '0, rdata);
      if (rdata !== DATA_W'(sb.tolerance))
        sb.report("tolerance readback", rdata, 32'(sb.tolerance));
    end
  endtask

  function automatic logic [COMP_W-1:0] jitter(logic [COMP_W-1:0] base, int unsigned span);
    int v;
    if (span >= 255) return COMP_W'($urandom);
    v = int'(base) + int'($urandom_range(0, span)) - int'(span / 2);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return COMP_W'(v);
  endfunction

  task automatic run_regions(input int unsigned n_pixels);
    int unsigned       sent;
    int unsigned       len;
    int unsigned       kind;
    int unsigned       span;
    logic [COMP_W-1:0] br;
    logic [COMP_W-1:0] bg;
    logic [COMP_W-1:0] bb;
    sent = 0;
    while (sent < n_pixels) begin
      kind = $urandom_range(0, 9);
      len  = (kind == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      span = (kind < 5) ? $urandom_range(0, 8) : 255;
      br   = COMP_W'($urandom);
      bg   = COMP_W'($urandom);
      bb   = COMP_W'($urandom);
      for (int k = 0; k < len; k++) begin
        send_pixel(jitter(br, span), jitter(bg, span), jitter(bb, span), k == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    int unsigned stall;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(0, snk_gap_max);
      if (hold_pending) begin
        stall        = LONG_HOLD;
        hold_pending = 1'b0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_homogeneous, out_spread, out_min_magnitude, out_max_magnitude);
    end
  end

  initial begin
    logic [DATA_W-1:0] tol_words [8];
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_red        <= '0;
    in_green      <= '0;
    in_blue       <= '0;
    in_last_pixel <= 1'b0;
    cfg_psel      <= 1'b0;
    cfg_penable   <= 1'b0;
    cfg_pwrite    <= 1'b0;
    cfg_paddr     <= '0;
    cfg_pwdata    <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single pixels at both ends, full-range region, spread either side of tolerance
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd1, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd100, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd115, 8'd0, 1'b1);
    send_pixel(8'd100, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd116, 1'b1);
    send_pixel(8'd3, 8'd4, 8'd1, 1'b1);
    send_pixel(8'd170, 8'd85, 8'd170, 1'b0);
    send_pixel(8'd85, 8'd170, 8'd85, 1'b1);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b1);

    // zero tolerance through an over-wide write, then a write to an unmapped address
    drain();
    program_register(TOL_ADDR, 32'hFFFF_FE00);
    send_pixel(8'd7, 8'd7, 8'd7, 1'b1);
    send_pixel(8'd7, 8'd7, 8'd7, 1'b0);
    send_pixel(8'd7, 8'd7, 8'd7, 1'b1);
    drain();
    program_register(UNUSED_ADDR, 32'h0000_0005);
    send_pixel(8'd9, 8'd9, 8'd9, 1'b1);

    tol_words = '{32'hFFFF_FFFF, 32'd1, 32'd16, 32'd442, 32'd0,
                  $urandom, $urandom_range(0, 40), $urandom};
    for (int p = 0; p < 8; p++) begin
      drain();
      program_register(TOL_ADDR, tol_words[p]);
      src_gap_max  = (p % 3 == 1) ? 0 : 6;
      snk_gap_max  = (p % 3 == 2) ? 0 : 6;
      hold_pending = (p == 4);
      run_regions(205);
    end
    drain();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
